### sv/equi_width_histogram_binner_macros.svh
// Assertion macros for the equi-width histogram binner checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef EQUI_WIDTH_HISTOGRAM_BINNER_MACROS_SVH
`define EQUI_WIDTH_HISTOGRAM_BINNER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EWHB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EWHB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ewhb_pkg.sv
// Shared types and constants of the equi-width histogram binner.
// No dependencies; used by every module of the block.
package ewhb_pkg;

  localparam int MAX_FIELDS_DEF  = 4;
  localparam int MAX_BUCKETS_DEF = 15;

  localparam int VAL_W     = 64;
  localparam int CNT_W     = 32;
  localparam int FLD_W     = 2;
  localparam int BKT_W     = 4;
  localparam int FCFG_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_CNT_W = $clog2(VAL_W);

  localparam logic [VAL_W-1:0]  MIN_VALUE_RST    = 64'd0;
  localparam logic [VAL_W-1:0]  MAX_VALUE_RST    = 64'd6553600;
  localparam logic [BKT_W-1:0]  BUCKET_COUNT_RST = 4'd10;
  localparam logic [FCFG_W-1:0] FIELD_COUNT_RST  = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_VALUE    = 2'd0,
    CFG_MAX_VALUE    = 2'd1,
    CFG_BUCKET_COUNT = 2'd2,
    CFG_FIELD_COUNT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDGES,
    ST_RUN,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    EG_IDLE,
    EG_DIV,
    EG_STEP
  } eg_state_t;

  typedef struct packed {
    logic [FLD_W-1:0]        field_index;
    logic signed [VAL_W-1:0] sample;
    logic                    end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [FLD_W-1:0]        hist_field;
    logic [BKT_W-1:0]        bucket_index;
    logic [CNT_W-1:0]        bucket_total;
    logic signed [VAL_W-1:0] field_sum;
    logic                    last_result;
  } out_item_t;

  // One edge write from the edge generator; done marks the final edge.
  typedef struct packed {
    logic                    we;
    logic [BKT_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
    logic                    done;
  } edge_wr_t;

endpackage

### sv/equi_width_histogram_binner.sv
// Top level of the equi-width histogram binner.
// Depends on ewhb_pkg and ewhb_edge_gen.
//
// Usage:
//   Input items arrive on in_item and are taken on a clock edge with start
//   high and busy low. Each item adds one sample to the histogram of its
//   field. The first item of a buffer latches bucket_count and field_count
//   and waits while the bucket edges are built: a bit-serial divide, then
//   an edge step per bucket, with busy held high until the last edge is written.
//   After that, items of the buffer are taken one per cycle; the count
//   memory is read, bumped and written back over two stages, with
//   forwarding when back-to-back items hit the same bucket.
//   The item with end_of_buffer closes the buffer: busy rises, and after
//   that item has passed stage 1 and stage 2, the flush shows one result
//   per (field, bucket) on out_item, field-major, fields*(buckets+1) in all,
//   one per cycle, each marked by out_strobe for exactly one cycle.
//   The receiver cannot stall; it must take every result.
//   Counts and sums are cleared as the flush ends and busy drops after the
//   result flagged last_result. Configuration is written through cfg_we,
//   cfg_index and cfg_wdata between buffers.
//   Reset (rst_n low, synchronous) clears all counts and sums through
//   valid bits and restores the register defaults; no clearing pass.
module equi_width_histogram_binner #(
  parameter int MAX_FIELDS  = ewhb_pkg::MAX_FIELDS_DEF,
  parameter int MAX_BUCKETS = ewhb_pkg::MAX_BUCKETS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  ewhb_pkg::in_item_t                  in_item,
  output logic                                out_strobe,
  output ewhb_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [ewhb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ewhb_pkg::VAL_W-1:0]          cfg_wdata
);

  localparam int VAL_W     = ewhb_pkg::VAL_W;
  localparam int CNT_W     = ewhb_pkg::CNT_W;
  localparam int BKT_W     = ewhb_pkg::BKT_W;
  localparam int FLD_W     = ewhb_pkg::FLD_W;
  localparam int FCFG_W    = ewhb_pkg::FCFG_W;
  localparam int SLOTS     = MAX_BUCKETS + 1;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int FIDX_W    = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int FCNT_W    = $clog2(MAX_FIELDS + 1);
  localparam int CNT_DEPTH = MAX_FIELDS * SLOTS;
  localparam int CADDR_W   = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;

  // Saturating signed add, matching two's complement overflow rules.
  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] s;
    s = a + b;
    if ((a[VAL_W-1] == b[VAL_W-1]) && (s[VAL_W-1] != a[VAL_W-1])) begin
      sat_add = a[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      sat_add = s;
    end
  endfunction

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic signed [VAL_W-1:0] min_value_r;
  logic signed [VAL_W-1:0] max_value_r;
  logic [BKT_W-1:0]        bucket_count_r;
  logic [FCFG_W-1:0]       field_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r    <= ewhb_pkg::MIN_VALUE_RST;
      max_value_r    <= ewhb_pkg::MAX_VALUE_RST;
      bucket_count_r <= ewhb_pkg::BUCKET_COUNT_RST;
      field_count_r  <= ewhb_pkg::FIELD_COUNT_RST;
    end else if (cfg_we) begin
      unique case (ewhb_pkg::cfg_reg_t'(cfg_index))
        ewhb_pkg::CFG_MIN_VALUE:    min_value_r    <= cfg_wdata;
        ewhb_pkg::CFG_MAX_VALUE:    max_value_r    <= cfg_wdata;
        ewhb_pkg::CFG_BUCKET_COUNT: bucket_count_r <= cfg_wdata[BKT_W-1:0];
        ewhb_pkg::CFG_FIELD_COUNT:  field_count_r  <= cfg_wdata[FCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------
  ewhb_pkg::state_t state_r, state_nxt;
  logic             accept;
  logic             eob_pend_r;
  logic [SLOT_W-1:0] nb_lat_r;
  logic [FCNT_W-1:0] nf_lat_r;

  ewhb_pkg::edge_wr_t eg_wr;

  logic              s1_vld_r;
  ewhb_pkg::in_item_t s1_item_r;
  logic              s2_vld_r;
  logic              s2_eob_r;

  logic              out_strobe_r;
  ewhb_pkg::out_item_t out_item_r;

  // ---------------------------------------------------------------
  // Buffer start: clamp counts, derive the range for edge generation
  // ---------------------------------------------------------------
  logic [BKT_W-1:0]        nb_cl4;
  logic [FCFG_W-1:0]       nf_cl3;
  logic                    range_ok;
  logic [VAL_W-1:0]        range_span;
  logic signed [VAL_W-1:0] range_base;

  always_comb begin
    if (bucket_count_r == '0) begin
      nb_cl4 = BKT_W'(1);
    end else if (bucket_count_r > BKT_W'(MAX_BUCKETS)) begin
      nb_cl4 = BKT_W'(MAX_BUCKETS);
    end else begin
      nb_cl4 = bucket_count_r;
    end
    if (field_count_r == '0) begin
      nf_cl3 = FCFG_W'(1);
    end else if (field_count_r > FCFG_W'(MAX_FIELDS)) begin
      nf_cl3 = FCFG_W'(MAX_FIELDS);
    end else begin
      nf_cl3 = field_count_r;
    end
  end

  // Empty or inverted range: span 0 and base max puts every edge at max.
  assign range_ok   = max_value_r > min_value_r;
  assign range_span = range_ok ? VAL_W'(max_value_r - min_value_r) : '0;
  assign range_base = range_ok ? min_value_r : max_value_r;

  ewhb_edge_gen #(
    .MAX_BUCKETS(MAX_BUCKETS)
  ) u_edge_gen (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept && (state_r == ewhb_pkg::ST_IDLE)),
    .span   (range_span),
    .base   (range_base),
    .nb     (SLOT_W'(nb_cl4)),
    .edge_wr(eg_wr)
  );

  // Edge table: written one edge per cycle, compared in parallel.
  logic signed [VAL_W-1:0] edge_r [MAX_BUCKETS];

  always_ff @(posedge clk) begin
    for (int b = 0; b < MAX_BUCKETS; b++) begin
      if (eg_wr.we && (eg_wr.idx == BKT_W'(b))) begin
        edge_r[b] <= eg_wr.value;
      end
    end
  end

  // ---------------------------------------------------------------
  // Flush sequencing
  // ---------------------------------------------------------------
  logic [FIDX_W-1:0] fl_f_r;
  logic [SLOT_W-1:0] fl_b_r;
  logic              fl_done_r;
  logic              fl_issue;
  logic              fl_last_issue;
  logic              fl_b_last;
  logic [CADDR_W-1:0] fl_addr;

  assign fl_issue      = (state_r == ewhb_pkg::ST_FLUSH) && !fl_done_r;
  assign fl_b_last     = fl_b_r == nb_lat_r;
  assign fl_last_issue = fl_issue && fl_b_last && (int'(fl_f_r) == int'(nf_lat_r) - 1);
  assign fl_addr       = CADDR_W'(int'(fl_f_r) * SLOTS + int'(fl_b_r));

  // ---------------------------------------------------------------
  // State machine
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ewhb_pkg::ST_IDLE:  if (accept) state_nxt = ewhb_pkg::ST_EDGES;
      ewhb_pkg::ST_EDGES: if (eg_wr.done) state_nxt = ewhb_pkg::ST_RUN;
      // leave once the closing item has written its bucket back
      ewhb_pkg::ST_RUN:   if (s2_vld_r && s2_eob_r) state_nxt = ewhb_pkg::ST_FLUSH;
      ewhb_pkg::ST_FLUSH: begin
        if (out_strobe_r && out_item_r.last_result) state_nxt = ewhb_pkg::ST_IDLE;
      end
      default:            state_nxt = ewhb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = !((state_r == ewhb_pkg::ST_IDLE) ||
             ((state_r == ewhb_pkg::ST_RUN) && !eob_pend_r));
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ewhb_pkg::ST_IDLE;
      eob_pend_r <= 1'b0;
      nb_lat_r   <= SLOT_W'(1);
      nf_lat_r   <= FCNT_W'(1);
      fl_f_r     <= '0;
      fl_b_r     <= '0;
      fl_done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && (state_r == ewhb_pkg::ST_IDLE)) begin
        nb_lat_r <= SLOT_W'(nb_cl4);
        nf_lat_r <= FCNT_W'(nf_cl3);
      end
      // Hold off new items from the closing item until the flush is out.
      if (accept && in_item.end_of_buffer) begin
        eob_pend_r <= 1'b1;
      end else if (state_nxt == ewhb_pkg::ST_IDLE) begin
        eob_pend_r <= 1'b0;
      end
      if (state_nxt == ewhb_pkg::ST_IDLE) begin
        fl_f_r    <= '0;
        fl_b_r    <= '0;
        fl_done_r <= 1'b0;
      end else if (fl_issue) begin
        if (fl_b_last) begin
          fl_b_r <= '0;
          fl_f_r <= fl_f_r + FIDX_W'(1);
        end else begin
          fl_b_r <= fl_b_r + SLOT_W'(1);
        end
        if (fl_last_issue) fl_done_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: bucket search and memory read
  // ---------------------------------------------------------------
  logic [SLOT_W-1:0]  s1_slot;
  logic [FIDX_W-1:0]  s1_fsel;
  logic               s1_counted;
  logic [CADDR_W-1:0] s1_addr;

  // Lowest edge at or above the sample wins; none means overflow.
  always_comb begin
    s1_slot = nb_lat_r;
    for (int b = MAX_BUCKETS - 1; b >= 0; b--) begin
      if ((SLOT_W'(b) < nb_lat_r) && (edge_r[b] >= s1_item_r.sample)) begin
        s1_slot = SLOT_W'(b);
      end
    end
  end

  assign s1_fsel    = s1_item_r.field_index[FIDX_W-1:0];
  assign s1_counted = int'(s1_item_r.field_index) < int'(nf_lat_r);
  assign s1_addr    = CADDR_W'(int'(s1_fsel) * SLOTS + int'(s1_slot));

  logic s1_vld_nxt;
  assign s1_vld_nxt = (accept && (state_r == ewhb_pkg::ST_RUN)) ||
                      ((state_r == ewhb_pkg::ST_EDGES) && eg_wr.done);

  // Stage 2 registers
  logic               s2_cnt_en_r;
  logic [CADDR_W-1:0] s2_addr_r;
  logic [FIDX_W-1:0]  s2_fsel_r;
  logic [VAL_W-1:0]   s2_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_item_r <= in_item;
    s2_cnt_en_r <= s1_vld_r && s1_counted;
    s2_eob_r    <= s1_item_r.end_of_buffer;
    s2_addr_r   <= s1_addr;
    s2_fsel_r   <= s1_fsel;
    s2_sample_r <= s1_item_r.sample;
  end

  // ---------------------------------------------------------------
  // Count and sum memories, shared by update and flush
  // ---------------------------------------------------------------
  logic [CNT_W-1:0]   cnt_mem [CNT_DEPTH];
  logic [VAL_W-1:0]   sum_mem [MAX_FIELDS];
  logic [CNT_DEPTH-1:0]  cnt_valid_r;
  logic [MAX_FIELDS-1:0] sum_valid_r;

  logic [CADDR_W-1:0] rd_addr;
  logic [FIDX_W-1:0]  rd_f;
  logic [CNT_W-1:0]   cnt_q_r;
  logic [VAL_W-1:0]   sum_q_r;
  logic               cnt_vq_r;
  logic               sum_vq_r;

  logic               wr_en;
  logic [CNT_W-1:0]   cnt_cur;
  logic [VAL_W-1:0]   sum_cur;
  logic [CNT_W-1:0]   cnt_new;
  logic [VAL_W-1:0]   sum_new;

  logic               fwd_cnt_hit_r;
  logic               fwd_sum_hit_r;
  logic [CNT_W-1:0]   fwd_cnt_r;
  logic [VAL_W-1:0]   fwd_sum_r;

  assign rd_addr = (state_r == ewhb_pkg::ST_FLUSH) ? fl_addr : s1_addr;
  assign rd_f    = (state_r == ewhb_pkg::ST_FLUSH) ? fl_f_r : s1_fsel;
  assign wr_en   = s2_vld_r && s2_cnt_en_r;

  // Entries never written since the last clear read as zero; a write in
  // the same cycle as the read of its entry is taken from the bypass.
  always_comb begin
    if (fwd_cnt_hit_r) begin
      cnt_cur = fwd_cnt_r;
    end else begin
      cnt_cur = cnt_vq_r ? cnt_q_r : '0;
    end
    if (fwd_sum_hit_r) begin
      sum_cur = fwd_sum_r;
    end else begin
      sum_cur = sum_vq_r ? sum_q_r : '0;
    end
    cnt_new = (cnt_cur == {CNT_W{1'b1}}) ? cnt_cur : cnt_cur + CNT_W'(1);
    sum_new = sat_add(sum_cur, s2_sample_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[s2_addr_r] <= cnt_new;
      sum_mem[s2_fsel_r] <= sum_new;
    end
    cnt_q_r   <= cnt_mem[rd_addr];
    sum_q_r   <= sum_mem[rd_f];
    cnt_vq_r  <= cnt_valid_r[rd_addr];
    sum_vq_r  <= sum_valid_r[rd_f];
    fwd_cnt_r <= cnt_new;
    fwd_sum_r <= sum_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_valid_r   <= '0;
      sum_valid_r   <= '0;
      fwd_cnt_hit_r <= 1'b0;
      fwd_sum_hit_r <= 1'b0;
    end else begin
      fwd_cnt_hit_r <= wr_en && (s2_addr_r == rd_addr);
      fwd_sum_hit_r <= wr_en && (s2_fsel_r == rd_f);
      // Drop every count and sum once the last entry has been read out.
      if (fl_last_issue) begin
        cnt_valid_r <= '0;
        sum_valid_r <= '0;
      end else if (wr_en) begin
        cnt_valid_r[s2_addr_r] <= 1'b1;
        sum_valid_r[s2_fsel_r] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------
  // Flush output: read data arrives in the cycle after issue
  // ---------------------------------------------------------------
  logic              p1_vld_r;
  logic [FIDX_W-1:0] p1_f_r;
  logic [SLOT_W-1:0] p1_b_r;
  logic              p1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      p1_vld_r     <= fl_issue;
      out_strobe_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_f_r    <= fl_f_r;
    p1_b_r    <= fl_b_r;
    p1_last_r <= fl_last_issue;
    out_item_r.hist_field   <= FLD_W'(p1_f_r);
    out_item_r.bucket_index <= BKT_W'(p1_b_r);
    out_item_r.bucket_total <= cnt_cur;
    out_item_r.field_sum    <= sum_cur;
    out_item_r.last_result  <= p1_last_r;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

### sv/ewhb_edge_gen.sv
// Bucket edge generator: bit-serial divide of the range by the bucket count,
// then one edge per cycle. Depends on ewhb_pkg.
module ewhb_edge_gen #(
  parameter int MAX_BUCKETS = ewhb_pkg::MAX_BUCKETS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ewhb_pkg::VAL_W-1:0]        span,
  input  logic signed [ewhb_pkg::VAL_W-1:0] base,
  input  logic [$clog2(MAX_BUCKETS+1)-1:0]  nb,
  output ewhb_pkg::edge_wr_t                edge_wr
);

  localparam int SLOT_W = $clog2(MAX_BUCKETS + 1);
  localparam int VAL_W  = ewhb_pkg::VAL_W;
  localparam int DCW    = ewhb_pkg::DIV_CNT_W;

  ewhb_pkg::eg_state_t state_r, state_nxt;

  logic [VAL_W-1:0]        num_r;
  logic [SLOT_W-1:0]       rem_r;
  logic [SLOT_W-1:0]       nb_r;
  logic signed [VAL_W-1:0] base_r;
  logic [SLOT_W-1:0]       acc_r;
  logic [DCW-1:0]          cnt_r;

  logic [SLOT_W:0]         rem_sh;
  logic                    div_ge;
  logic [SLOT_W-1:0]       rem_div;
  logic [SLOT_W:0]         acc_sum;
  logic                    carry;
  logic [SLOT_W-1:0]       acc_step;
  logic signed [VAL_W-1:0] base_step;
  logic [SLOT_W-1:0]       nb_m1;
  logic                    div_last;
  logic                    step_last;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh  = {rem_r, num_r[VAL_W-1]};
  assign div_ge  = rem_sh >= {1'b0, nb_r};
  assign rem_div = div_ge ? SLOT_W'(rem_sh - {1'b0, nb_r}) : rem_sh[SLOT_W-1:0];

  // edge i = base + i*q + floor(i*r/n), carried forward incrementally
  assign acc_sum   = {1'b0, acc_r} + {1'b0, rem_r};
  assign carry     = acc_sum >= {1'b0, nb_r};
  assign acc_step  = carry ? SLOT_W'(acc_sum - {1'b0, nb_r}) : acc_sum[SLOT_W-1:0];
  assign base_step = base_r + $signed(num_r) + $signed({{(VAL_W-1){1'b0}}, carry});

  assign nb_m1     = nb_r - SLOT_W'(1);
  assign div_last  = cnt_r == {DCW{1'b1}};
  assign step_last = cnt_r == DCW'(nb_m1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ewhb_pkg::EG_IDLE: if (start) state_nxt = ewhb_pkg::EG_DIV;
      ewhb_pkg::EG_DIV:  if (div_last) state_nxt = ewhb_pkg::EG_STEP;
      ewhb_pkg::EG_STEP: if (step_last) state_nxt = ewhb_pkg::EG_IDLE;
      default:           state_nxt = ewhb_pkg::EG_IDLE;
    endcase
  end

  always_comb begin
    edge_wr.we    = state_r == ewhb_pkg::EG_STEP;
    edge_wr.idx   = ewhb_pkg::BKT_W'(cnt_r);
    edge_wr.value = base_step;
    edge_wr.done  = (state_r == ewhb_pkg::EG_STEP) && step_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ewhb_pkg::EG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ewhb_pkg::EG_IDLE: begin
        num_r  <= span;
        rem_r  <= '0;
        nb_r   <= nb;
        base_r <= base;
        acc_r  <= '0;
        cnt_r  <= '0;
      end
      ewhb_pkg::EG_DIV: begin
        num_r <= {num_r[VAL_W-2:0], div_ge};
        rem_r <= rem_div;
        cnt_r <= cnt_r + DCW'(1);
      end
      ewhb_pkg::EG_STEP: begin
        base_r <= base_step;
        acc_r  <= acc_step;
        cnt_r  <= cnt_r + DCW'(1);
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

endmodule

### sv/ewhb_checker.sv
// Port-level checker for the equi-width histogram binner, with its bind.
// Depends on ewhb_pkg and the assertion macros header.
`include "equi_width_histogram_binner_macros.svh"

module ewhb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input ewhb_pkg::in_item_t  in_item,
  input logic                out_strobe,
  input ewhb_pkg::out_item_t out_item
);

  // results only come out while the block holds off new items
  `EWHB_ASSERT_SAME(a_out_while_busy, out_strobe, busy, "result shown while not busy")

  // closing item must stop intake right away
  `EWHB_ASSERT_NEXT(a_eob_busy, start && !busy && in_item.end_of_buffer, busy, "intake open after end_of_buffer")

  // a flush is one unbroken run of results
  `EWHB_ASSERT_NEXT(a_flush_contig, out_strobe && !out_item.last_result, out_strobe, "gap inside a flush")

  `EWHB_ASSERT_NEXT(a_last_ends, out_strobe && out_item.last_result, !out_strobe, "result after last_result")

endmodule

bind equi_width_histogram_binner ewhb_checker u_ewhb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_strobe(out_strobe),
  .out_item  (out_item)
);

### verif/histogram_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the equi-width histogram binner: tracks register writes, bins
// each accepted item and compares every flushed bucket result in order.
// Depends on ewhb_pkg.
module histogram_checker
  import ewhb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             in_item,
  input  logic                 out_strobe,
  input  out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  localparam int SLOT_N = MAX_BUCKETS_DEF + 1;

  logic [VAL_W-1:0]        reg_min;
  logic [VAL_W-1:0]        reg_max;
  logic [BKT_W-1:0]        reg_buckets;
  logic [FCFG_W-1:0]       reg_fields;

  logic signed [VAL_W-1:0] edge_val [MAX_BUCKETS_DEF];
  logic [CNT_W-1:0]        tally [MAX_FIELDS_DEF][SLOT_N];
  logic [VAL_W-1:0]        sum_acc [MAX_FIELDS_DEF];
  bit                      between_buffers;
  int                      nb_live;
  int                      nf_live;
  int                      miss_total = 0;
  out_item_t               flush_queue [$];

  function automatic logic [VAL_W-1:0] sat_add64(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] s;
    s = a + b;
    if (a[VAL_W-1] == b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1])
      return a[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    return s;
  endfunction

  task automatic report_miss(string what, logic [VAL_W-1:0] got_v, logic [VAL_W-1:0] want_v);
    miss_total++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got_v, want_v);
  endtask

  task automatic clear_tallies();
    foreach (tally[i, j]) tally[i][j] = '0;
    foreach (sum_acc[i]) sum_acc[i] = '0;
  endtask

  // Latch the sizes and build the edges on the first item of a buffer.
  task automatic latch_buffer();
    logic [VAL_W-1:0] width, quo, rem, off;
    nb_live = (reg_buckets == 0) ? 1 : int'(reg_buckets);
    if (reg_fields == 0)
      nf_live = 1;
    else if (int'(reg_fields) > MAX_FIELDS_DEF)
      nf_live = MAX_FIELDS_DEF;
    else
      nf_live = int'(reg_fields);
    width = reg_max - reg_min;
    quo   = width / 64'(nb_live);
    rem   = width % 64'(nb_live);
    for (int i = 1; i <= nb_live; i++) begin
      if ($signed(reg_max) > $signed(reg_min)) begin
        off = 64'(i) * quo + (64'(i) * rem) / 64'(nb_live);
        edge_val[i-1] = reg_min + off;
      end else begin
        edge_val[i-1] = reg_max;
      end
    end
    between_buffers = 1'b0;
  endtask

  // Bin one item; on end of buffer queue the whole flush, field-major.
  task automatic tally_item(in_item_t it);
    int        fld, slot, total, n;
    out_item_t want;
    if (between_buffers) latch_buffer();
    fld = int'(it.field_index);
    if (fld < nf_live) begin
      slot = nb_live;
      for (int b = nb_live - 1; b >= 0; b--)
        if (edge_val[b] >= $signed(it.sample)) slot = b;
      if (tally[fld][slot] != '1) tally[fld][slot] = tally[fld][slot] + CNT_W'(1);
      sum_acc[fld] = sat_add64(sum_acc[fld], it.sample);
    end
    if (!it.end_of_buffer) return;
    total = nf_live * (nb_live + 1);
    n = 0;
    for (int k = 0; k < nf_live; k++) begin
      for (int b = 0; b <= nb_live; b++) begin
        n++;
        want.hist_field   = FLD_W'(k);
        want.bucket_index = BKT_W'(b);
        want.bucket_total = tally[k][b];
        want.field_sum    = sum_acc[k];
        want.last_result  = (n == total);
        flush_queue = {flush_queue, want};
      end
    end
    clear_tallies();
    between_buffers = 1'b1;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (flush_queue.size() == 0) begin
      report_miss("unexpected result", VAL_W'(got.bucket_index), '0);
      return;
    end
    want = flush_queue.pop_front();
    if (got.hist_field !== want.hist_field)
      report_miss("hist_field", VAL_W'(got.hist_field), VAL_W'(want.hist_field));
    if (got.bucket_index !== want.bucket_index)
      report_miss("bucket_index", VAL_W'(got.bucket_index), VAL_W'(want.bucket_index));
    if (got.bucket_total !== want.bucket_total)
      report_miss("bucket_total", VAL_W'(got.bucket_total), VAL_W'(want.bucket_total));
    if (got.field_sum !== want.field_sum)
      report_miss("field_sum", got.field_sum, want.field_sum);
    if (got.last_result !== want.last_result)
      report_miss("last_result", VAL_W'(got.last_result), VAL_W'(want.last_result));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reg_min         = MIN_VALUE_RST;
      reg_max         = MAX_VALUE_RST;
      reg_buckets     = BUCKET_COUNT_RST;
      reg_fields      = FIELD_COUNT_RST;
      between_buffers = 1'b1;
      nb_live         = 1;
      nf_live         = 1;
      clear_tallies();
      flush_queue.delete();
    end else begin
      if (out_strobe) check_result(out_item);
      // An item taken on the same edge as a register write sees the old value.
      if (start && !busy) tally_item(in_item);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_MIN_VALUE:    reg_min     = cfg_wdata;
          CFG_MAX_VALUE:    reg_max     = cfg_wdata;
          CFG_BUCKET_COUNT: reg_buckets = cfg_wdata[BKT_W-1:0];
          CFG_FIELD_COUNT:  reg_fields  = cfg_wdata[FCFG_W-1:0];
          default: ;
        endcase
      end
    end
    // Publish with nonblocking updates so the stimulus side never races them.
    fail_count <= miss_total;
    pending    <= flush_queue.size();
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Top of the histogram binner testbench: clock, reset, register writes and
// bursty item stimulus; checking lives in histogram_checker.
// Depends on ewhb_pkg, histogram_checker and equi_width_histogram_binner.
module tb;
  import ewhb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 300;
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] ONE_Q16 = 64'd65536;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  in_item_t             in_item   = '0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_wdata = '0;
  logic                 busy;
  logic                 out_strobe;
  out_item_t            out_item;
  int                   fail_count;
  int                   pending;
  int                   cycle_count = 0;

  // Current range and sizes, kept only to aim the random samples.
  logic [VAL_W-1:0]     span_lo   = MIN_VALUE_RST;
  logic [VAL_W-1:0]     span_hi   = MAX_VALUE_RST;
  int                   nb_shape  = 10;
  int                   nf_shape  = 1;

  // Sender pacing: a burst runs burst_left more items; steady drops the gaps.
  int                   burst_left = 0;
  bit                   steady     = 1'b1;

  equi_width_histogram_binner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  histogram_checker u_scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes it. A new burst may
  // open with a random gap, which lands on whatever phase the block is in.
  task automatic send_item(logic [FLD_W-1:0] fld, logic [VAL_W-1:0] val, bit eob);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= in_item_t'{field_index: fld, sample: val, end_of_buffer: eob};
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every queued result has come and the block is
  // free, then give the count pipeline time to drain.
  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  // Write all four registers back to back; junk rides in the unused upper
  // bits of the narrow ones.
  task automatic write_config(logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi, int nb, int nf);
    logic [VAL_W-1:0] noise;
    noise = {$urandom, $urandom};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_VALUE;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_MAX_VALUE;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= CFG_BUCKET_COUNT;
    cfg_wdata <= {noise[VAL_W-1:BKT_W], BKT_W'(nb)};
    @(posedge clk);
    cfg_index <= CFG_FIELD_COUNT;
    cfg_wdata <= {noise[VAL_W-1:FCFG_W], FCFG_W'(nf)};
    @(posedge clk);
    cfg_we   <= 1'b0;
    span_lo  = lo;
    span_hi  = hi;
    nb_shape = (nb == 0) ? 1 : nb;
    nf_shape = (nf == 0) ? 1 : (nf > MAX_FIELDS_DEF) ? MAX_FIELDS_DEF : nf;
  endtask

  // One buffer of random samples, mostly aimed inside the range and at the
  // bucket edges; the last item closes the buffer.
  task automatic random_buffer(output int sent);
    int               len;
    logic [VAL_W-1:0] width, stride, noise, val;
    logic [FLD_W-1:0] fld;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      noise = {$urandom, $urandom};
      width = span_hi - span_lo;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          if ($signed(span_hi) <= $signed(span_lo))
            val = span_hi + 64'($urandom_range(0, 2)) - 64'd1;
          else if (&width)
            val = noise;
          else
            val = span_lo + noise % (width + 64'd1);
        end
        5, 6: begin
          stride = ($signed(span_hi) > $signed(span_lo)) ? width / 64'(nb_shape) : 64'd0;
          val = span_lo + stride * 64'($urandom_range(1, nb_shape))
                + 64'($urandom_range(0, 2)) - 64'd1;
        end
        7: val = $urandom_range(0, 1) ? span_hi + 64'($urandom_range(1, 1000))
                                      : span_lo - 64'($urandom_range(0, 1000));
        8: val = noise;
        default: begin
          case ($urandom_range(0, 3))
            0:       val = VAL_MAX;
            1:       val = VAL_MIN;
            2:       val = '0;
            default: val = '1;
          endcase
        end
      endcase
      // Mostly fields inside the latched count; the rest may fall outside it and be dropped by the block.
      fld = ($urandom_range(0, 9) == 0) ? FLD_W'($urandom_range(0, 3))
                                        : FLD_W'($urandom_range(0, nf_shape - 1));
      send_item(fld, val, i == len - 1);
    end
    sent = len;
  endtask

  initial begin
    int items;
    int got;
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: range 0..100.0, ten buckets, one field.
    // Edges are exact multiples of 10.0, so hit them and their neighbors.
    send_item(2'd0, '0, 1'b0);
    send_item(2'd0, 64'd655360, 1'b0);
    send_item(2'd0, 64'd655361, 1'b0);
    send_item(2'd0, MAX_VALUE_RST, 1'b0);
    send_item(2'd0, MAX_VALUE_RST + 64'd1, 1'b0);
    send_item(2'd0, VAL_MIN, 1'b0);
    send_item(2'd0, VAL_MAX, 1'b0);
    send_item(2'd1, 64'd5, 1'b0);
    // Field beyond the latched count: not counted, but it still flushes.
    send_item(2'd3, 64'd7, 1'b1);
    settle();

    // Sum saturates high, then low.
    send_item(2'd0, VAL_MAX, 1'b0);
    send_item(2'd0, VAL_MAX, 1'b1);
    send_item(2'd0, VAL_MIN, 1'b0);
    send_item(2'd0, VAL_MIN, 1'b0);
    send_item(2'd0, '1, 1'b1);
    settle();

    // Registers rewritten inside an open buffer apply only to the next one,
    // so the closing item on field 2 is still out of range here.
    send_item(2'd0, 64'd100, 1'b0);
    settle();
    write_config(VAL_MIN, VAL_MAX, 15, 4);
    send_item(2'd2, 64'd200, 1'b1);
    settle();
    send_item(2'd3, VAL_MAX, 1'b1);
    settle();

    // Random phases: the first few pin the corner settings, later ones roll
    // their own. Every fourth phase runs without sender gaps.
    items = 0;
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      case (phase)
        0: write_config(VAL_MIN, VAL_MAX, 15, 4);
        1: write_config(-64'd10 * ONE_Q16, 64'd10 * ONE_Q16, 0, 0);
        2: write_config('0, 64'd1, 1, 7);
        3: write_config(64'd12345, 64'd12345, 5, 2);
        4: write_config(64'd1000, -64'd1000, 3, 3);
        5: write_config('1, '0, 15, 4);
        6: write_config(MIN_VALUE_RST, MAX_VALUE_RST, 10, 1);
        default: begin
          span_lo = $signed({$urandom, $urandom}) >>> $urandom_range(0, 62);
          span_hi = span_lo + ({$urandom, $urandom} >> $urandom_range(0, 63));
          write_config(span_lo, span_hi, $urandom_range(0, 15),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                   : $urandom_range(1, 4));
        end
      endcase
      steady = (phase % 4 == 3);
      repeat ($urandom_range(3, 6)) begin
        random_buffer(got);
        items += got;
      end
      settle();
      phase++;
    end

    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
